/* src/urm_pkg.sv */
// Shared types and constants for the ultrasonic range meter.
// No dependencies; imported by every module of the block.
package urm_pkg;

   // register map, index is paddr[3:2]
   localparam int REG_INDEX_BITS = 2;
   localparam int ADDR_BITS = 4;
   localparam logic [REG_INDEX_BITS-1:0] REG_TRIGGER_TICKS = 2'd0;
   localparam logic [REG_INDEX_BITS-1:0] REG_ECHO_TIMEOUT = 2'd1;
   localparam logic [REG_INDEX_BITS-1:0] REG_GAP_TICKS = 2'd2;
   localparam logic [REG_INDEX_BITS-1:0] REG_TICKS_PER_INCH = 2'd3;

   // register widths and reset values
   localparam int TRIGGER_BITS = 8;
   localparam int LIMIT_BITS = 20;
   localparam int DIVISOR_BITS = 8;
   localparam logic [TRIGGER_BITS-1:0] TRIGGER_RESET = 8'd11;
   localparam logic [LIMIT_BITS-1:0] TIMEOUT_RESET = 20'd1000000;
   localparam logic [LIMIT_BITS-1:0] GAP_RESET = 20'd100000;
   localparam logic [DIVISOR_BITS-1:0] TICKS_PER_INCH_RESET = 8'd148;

   // result fields
   localparam int WHOLE_BITS = 20;
   localparam int HUND_BITS = 7;
   localparam logic [WHOLE_BITS-1:0] WHOLE_MAX = 20'hFFFFF;
   localparam logic [HUND_BITS-1:0] HUND_MAX = 7'd99;

   // scaled remainder feeding the hundredths pass
   localparam int FRAC_BITS = 15;
   localparam logic [FRAC_BITS-1:0] FRAC_SCALE = 15'd100;

   // configuration seen by the core
   typedef struct packed {
      logic [TRIGGER_BITS-1:0] trigger_ticks;
      logic [LIMIT_BITS-1:0]   echo_timeout_ticks;
      logic [LIMIT_BITS-1:0]   gap_ticks;
      logic [DIVISOR_BITS-1:0] ticks_per_inch;
   } cfg_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // measurement phase
   typedef enum logic [3:0] {
      PH_TRIG = 4'b0001,
      PH_WAIT = 4'b0010,
      PH_MEAS = 4'b0100,
      PH_GAP  = 4'b1000
   } phase_type;

   // sequencer around the shared divider
   typedef enum logic [2:0] {
      SQ_IDLE  = 3'b001,
      SQ_WHOLE = 3'b010,
      SQ_FRAC  = 3'b100
   } seq_type;

endpackage

/* src/urm_csr.sv */
// APB-style configuration registers of the range meter.
// Depends on urm_pkg for the register map and reset values.
module urm_csr
   import urm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type                   cfg_ff;
   cfg_type                   cfg_in;
   logic                      wr_en;
   logic [REG_INDEX_BITS-1:0] reg_index;

   assign pready = 1'b1;
   assign wr_en = psel && penable && pwrite;
   assign reg_index = paddr[ADDR_BITS-1:2];
   assign cfg = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_TRIGGER_TICKS:  cfg_in.trigger_ticks = pwdata[TRIGGER_BITS-1:0];
            REG_ECHO_TIMEOUT:   cfg_in.echo_timeout_ticks = pwdata[LIMIT_BITS-1:0];
            REG_GAP_TICKS:      cfg_in.gap_ticks = pwdata[LIMIT_BITS-1:0];
            REG_TICKS_PER_INCH: cfg_in.ticks_per_inch = pwdata[DIVISOR_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks <= TRIGGER_RESET;
         cfg_ff.echo_timeout_ticks <= TIMEOUT_RESET;
         cfg_ff.gap_ticks <= GAP_RESET;
         cfg_ff.ticks_per_inch <= TICKS_PER_INCH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (reg_index)
         REG_TRIGGER_TICKS:  prdata = 32'(cfg_ff.trigger_ticks);
         REG_ECHO_TIMEOUT:   prdata = 32'(cfg_ff.echo_timeout_ticks);
         REG_GAP_TICKS:      prdata = 32'(cfg_ff.gap_ticks);
         REG_TICKS_PER_INCH: prdata = 32'(cfg_ff.ticks_per_inch);
         default:            prdata = 32'd0;
      endcase
   end

endmodule

/* src/urm_div.sv */
// Restoring serial divider, one quotient bit per cycle, 8-bit divisor.
// Depends on urm_pkg for the divisor width and status struct.
module urm_div
   import urm_pkg::*;
#(
   parameter int DW = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DW-1:0]           dividend,
   input  logic [DIVISOR_BITS-1:0] divisor,
   output logic [DW-1:0]           quotient,
   output logic [DIVISOR_BITS-1:0] remainder,
   output div_status_type          status
);

   localparam int CNT_BITS = $clog2(DW);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [DW-1:0]           num_ff, num_in;
   logic [DIVISOR_BITS-1:0] rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0] dsr_ff, dsr_in;
   logic [DIVISOR_BITS:0]   trial;
   logic [DIVISOR_BITS:0]   diff;
   logic                    fits;

   // one trial subtract per cycle
   assign trial = {rem_ff, num_ff[DW-1]};
   assign diff = trial - {1'b0, dsr_ff};
   assign fits = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         count_in = '0;
         num_in = dividend;
         rem_in = '0;
         // a zero divisor counts as one
         dsr_in = (divisor == '0) ? DIVISOR_BITS'(1) : divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[DW-2:0], fits};
         rem_in = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         count_in = count_ff + CNT_BITS'(1);
         if (count_ff == CNT_BITS'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = num_ff;
   assign remainder = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

/* src/ultrasonic_range_meter_top.sv */
// Ultrasonic range meter top level: tick handshake, phase control, result register.
// Depends on urm_pkg, urm_csr and urm_div.
//
// Each request is one microsecond tick with the sampled echo level, and each
// tick gives exactly one response (trigger drive, reading, lost flag). A tick
// on which echo falls runs the shared serial divider twice, once for whole
// inches and once for the hundredths, one quotient bit per cycle with
// DW = max(COUNT_BITS, 15) bits; no new tick is taken until both passes are
// done. A new request is taken when the sequencer is idle and the response
// register is empty or being read in the same cycle.
module ultrasonic_range_meter_top
   import urm_pkg::*;
#(
   parameter int COUNT_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_echo_level,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_trigger_level,
   output logic                  rsp_reading_valid,
   output logic                  rsp_echo_lost,
   output logic [WHOLE_BITS-1:0] rsp_whole_inches,
   output logic [HUND_BITS-1:0]  rsp_hundredths,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_BITS-1:0]  paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int DW = (COUNT_BITS > FRAC_BITS) ? COUNT_BITS : FRAC_BITS;
   localparam int CW = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
   localparam logic [CW-1:0] CNT_MAX = CW'({COUNT_BITS{1'b1}});

   cfg_type                 cfg;
   div_status_type          div_status;
   logic                    div_start;
   logic [DW-1:0]           div_dividend;
   logic [DW-1:0]           div_quotient;
   logic [DIVISOR_BITS-1:0] div_remainder;
   logic [FRAC_BITS-1:0]    frac_num;

   phase_type               phase_ff, phase_in;
   seq_type                 seq_ff, seq_in;
   logic [COUNT_BITS-1:0]   elapsed_ff, elapsed_in;
   logic [COUNT_BITS-1:0]   width_ff, width_in;
   logic [COUNT_BITS-1:0]   elapsed_inc;
   logic [COUNT_BITS-1:0]   width_inc;
   logic                    accept;
   logic                    tick_trig;
   logic                    tick_lost;
   logic                    tick_reading;
   logic                    whole_over;
   logic [WHOLE_BITS-1:0]   whole_ff, whole_in;
   logic                    clamp_ff, clamp_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_trig_ff, rsp_trig_in;
   logic                    rsp_read_ff, rsp_read_in;
   logic                    rsp_lost_ff, rsp_lost_in;
   logic [WHOLE_BITS-1:0]   rsp_whole_ff, rsp_whole_in;
   logic [HUND_BITS-1:0]    rsp_hund_ff, rsp_hund_in;

   // limit clipped to the counter range
   function automatic logic [CW-1:0] eff_limit(input logic [CW-1:0] lim);
      return (lim > CNT_MAX) ? CNT_MAX : lim;
   endfunction

   urm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   urm_div #(
      .DW (DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (cfg.ticks_per_inch),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_status)
   );

   // handshake
   assign req_ready = (seq_ff == SQ_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;

   // saturating increments
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + COUNT_BITS'(1);
   assign width_inc = (width_ff == '1) ? width_ff : width_ff + COUNT_BITS'(1);

   // per-tick phase update
   always_comb begin
      phase_in = phase_ff;
      elapsed_in = elapsed_ff;
      width_in = width_ff;
      tick_trig = 1'b0;
      tick_lost = 1'b0;
      tick_reading = 1'b0;
      case (phase_ff)
         PH_WAIT, PH_MEAS: begin
            elapsed_in = elapsed_inc;
            if (CW'(elapsed_inc) >= eff_limit(CW'(cfg.echo_timeout_ticks))) begin
               tick_lost = 1'b1;
               phase_in = PH_TRIG;
               elapsed_in = '0;
            end else if (phase_ff == PH_WAIT) begin
               if (req_echo_level) begin
                  width_in = COUNT_BITS'(1);
                  phase_in = PH_MEAS;
               end
            end else if (req_echo_level) begin
               width_in = width_inc;
            end else begin
               tick_reading = 1'b1;
               elapsed_in = '0;
               phase_in = (cfg.gap_ticks == '0) ? PH_TRIG : PH_GAP;
            end
         end
         PH_GAP: begin
            elapsed_in = elapsed_inc;
            if (CW'(elapsed_inc) >= eff_limit(CW'(cfg.gap_ticks))) begin
               phase_in = PH_TRIG;
               elapsed_in = '0;
            end
         end
         default: begin
            tick_trig = 1'b1;
            elapsed_in = elapsed_inc;
            if (CW'(elapsed_inc) >= eff_limit(CW'(cfg.trigger_ticks))) begin
               phase_in = PH_WAIT;
               elapsed_in = '0;
               width_in = '0;
            end else begin
               phase_in = PH_TRIG;
            end
         end
      endcase
   end

   // divider passes: width / divisor, then 100 * remainder / divisor
   assign frac_num = FRAC_BITS'(div_remainder) * FRAC_SCALE;
   assign whole_over = {WHOLE_BITS'(0), div_quotient} > {DW'(0), WHOLE_MAX};

   always_comb begin
      div_start = 1'b0;
      div_dividend = DW'(width_ff);
      seq_in = seq_ff;
      whole_in = whole_ff;
      clamp_in = clamp_ff;
      case (seq_ff)
         SQ_IDLE: begin
            if (accept && tick_reading) begin
               div_start = 1'b1;
               seq_in = SQ_WHOLE;
            end
         end
         SQ_WHOLE: begin
            if (div_status.done) begin
               div_start = 1'b1;
               div_dividend = DW'(frac_num);
               clamp_in = whole_over;
               whole_in = whole_over ? WHOLE_MAX : WHOLE_BITS'(div_quotient);
               seq_in = SQ_FRAC;
            end
         end
         SQ_FRAC: begin
            if (div_status.done) begin
               seq_in = SQ_IDLE;
            end
         end
         default: seq_in = SQ_IDLE;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_trig_in = rsp_trig_ff;
      rsp_read_in = rsp_read_ff;
      rsp_lost_in = rsp_lost_ff;
      rsp_whole_in = rsp_whole_ff;
      rsp_hund_in = rsp_hund_ff;
      if (accept && !tick_reading) begin
         rsp_valid_in = 1'b1;
         rsp_trig_in = tick_trig;
         rsp_read_in = 1'b0;
         rsp_lost_in = tick_lost;
         rsp_whole_in = '0;
         rsp_hund_in = '0;
      end else if (seq_ff == SQ_FRAC && div_status.done) begin
         rsp_valid_in = 1'b1;
         rsp_trig_in = 1'b0;
         rsp_read_in = 1'b1;
         rsp_lost_in = 1'b0;
         rsp_whole_in = whole_ff;
         rsp_hund_in = clamp_ff ? HUND_MAX : HUND_BITS'(div_quotient);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TRIG;
         elapsed_ff <= '0;
         width_ff <= '0;
         seq_ff <= SQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            elapsed_ff <= elapsed_in;
            width_ff <= width_in;
         end
         seq_ff <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      whole_ff <= whole_in;
      clamp_ff <= clamp_in;
      rsp_trig_ff <= rsp_trig_in;
      rsp_read_ff <= rsp_read_in;
      rsp_lost_ff <= rsp_lost_in;
      rsp_whole_ff <= rsp_whole_in;
      rsp_hund_ff <= rsp_hund_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_trigger_level = rsp_trig_ff;
   assign rsp_reading_valid = rsp_read_ff;
   assign rsp_echo_lost = rsp_lost_ff;
   assign rsp_whole_inches = rsp_whole_ff;
   assign rsp_hundredths = rsp_hund_ff;

endmodule

/* src/urm_checker.sv */
// Port-level checks on the range meter responses, bound to the top level.
// Depends on urm_pkg and ultrasonic_range_meter_top.
module urm_checker
   import urm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_trigger_level,
   input logic                  rsp_reading_valid,
   input logic                  rsp_echo_lost,
   input logic [WHOLE_BITS-1:0] rsp_whole_inches,
   input logic [HUND_BITS-1:0]  rsp_hundredths,
   input logic                  pready
);

   // a response is a trigger tick, a reading, a loss or none of them, never two of them
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_reading_valid && (rsp_trigger_level || rsp_echo_lost))
                    && !(rsp_trigger_level && rsp_echo_lost))
      else $error("response carries conflicting flags");

   // distance fields are zero outside a reading and hundredths stay below 100
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reading_valid || (rsp_whole_inches == '0 && rsp_hundredths == '0))
                    && rsp_hundredths <= HUND_MAX)
      else $error("distance fields out of range");

   // no new request while a response is stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reading_valid)
                                  && $stable(rsp_whole_inches) && $stable(rsp_hundredths))
      else $error("stalled response changed");

   // configuration port never waits
   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind ultrasonic_range_meter_top urm_checker u_urm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_trigger_level (rsp_trigger_level),
   .rsp_reading_valid (rsp_reading_valid),
   .rsp_echo_lost     (rsp_echo_lost),
   .rsp_whole_inches  (rsp_whole_inches),
   .rsp_hundredths    (rsp_hundredths),
   .pready            (pready)
);
